[sv/synchronous_epoch_folder_core_macros.svh]
// ----------------------------------------------------------------------------
// synchronous_epoch_folder_core_macros.svh
// assertion macros used by the epoch folder datapath
// ----------------------------------------------------------------------------
`ifndef SYNCHRONOUS_EPOCH_FOLDER_CORE_MACROS_SVH
`define SYNCHRONOUS_EPOCH_FOLDER_CORE_MACROS_SVH

// same-cycle implication on clk, off during reset
`define SEF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off during reset
`define SEF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/sef_pkg.sv]
// ----------------------------------------------------------------------------
// sef_pkg
// types and constants shared by the epoch folder controller and datapath
// ----------------------------------------------------------------------------
package sef_pkg;

	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FOLDING       = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SUM,
		S_DIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic acc_write;
		logic div_start;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last_fold;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

[sv/sef_ctrl.sv]
// ----------------------------------------------------------------------------
// sef_ctrl
// sequencer for accumulate, divide and result hand-off
// ----------------------------------------------------------------------------
module sef_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  sef_pkg::status_t status,
	output sef_pkg::cmd_t    cmd
);
	import sef_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (sample_valid) state_d = S_SUM;
			end
			S_SUM: begin
				state_d = status.last_fold ? S_DIV : S_IDLE;
			end
			S_DIV: begin
				if (status.div_last) state_d = S_OUT;
			end
			S_OUT: begin
				if (status.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		sample_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				sample_stall = 1'b0;
				cmd.capture  = sample_valid;
			end
			S_SUM: begin
				cmd.acc_write = !status.last_fold;
				cmd.div_start = status.last_fold;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_OUT: begin
				cmd.out_load = status.out_free;
			end
			default: begin
				sample_stall = 1'b1;
			end
		endcase
	end

endmodule

[sv/sef_dp.sv]
// ----------------------------------------------------------------------------
// sef_dp
// bin store, position and fold counters, serial divider and result register
// ----------------------------------------------------------------------------
`include "synchronous_epoch_folder_core_macros.svh"

module sef_dp #(
	parameter int MAX_BINS    = 1024,
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_FOLDING = 4096,
	parameter int CFG_W       = 13
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [sef_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]                  cfg_data,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	input  logic                              result_stall,
	output logic                              result_valid,
	output logic signed [SAMPLE_BITS-1:0]     average,
	output logic [$clog2(MAX_BINS)-1:0]       bin_index,
	output logic                              last,
	input  sef_pkg::cmd_t                     cmd,
	output sef_pkg::status_t                  status
);
	import sef_pkg::*;

	localparam int PW    = $clog2(MAX_BINS);
	localparam int LW    = PW + 1;
	localparam int CW    = $clog2(MAX_FOLDING);
	localparam int FW    = CW + 1;
	localparam int ACC_W = SAMPLE_BITS + CW;
	localparam int NW    = $clog2(ACC_W + 1);

	localparam logic [FW-1:0] FOLD_MAX = FW'(MAX_FOLDING);
	localparam logic [LW-1:0] LEN_MAX  = LW'(MAX_BINS);

	logic [FW-1:0]             fold_len_q;
	logic [LW-1:0]             vec_len_q;
	logic [PW-1:0]             pos_q;
	logic [CW-1:0]             fold_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [ACC_W-1:0]   rd_q;
	logic signed [ACC_W-1:0]   mem [MAX_BINS];

	logic [FW-1:0]             f_raw;
	logic [LW-1:0]             l_raw;
	logic signed [ACC_W-1:0]   base;
	logic signed [ACC_W-1:0]   sum;
	logic                      last_bin;
	logic                      advance;

	logic [ACC_W-1:0]          dvd_q;
	logic [FW-1:0]             rem_q;
	logic [NW-1:0]             cnt_q;
	logic                      neg_q;
	logic [PW-1:0]             idx_q;
	logic                      last_bin_q;
	logic [FW-1:0]             trial;
	logic                      ge;
	logic [ACC_W-1:0]          quot;

	logic                      result_valid_q;
	logic signed [SAMPLE_BITS-1:0] average_q;
	logic [PW-1:0]             bin_index_q;
	logic                      last_q;

	// configuration, saturated to the supported range
	assign f_raw = cfg_data[FW-1:0];
	assign l_raw = cfg_data[LW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_len_q <= FW'(1);
			vec_len_q  <= LEN_MAX;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FOLDING: begin
					if (f_raw == '0) fold_len_q <= FW'(1);
					else if (f_raw > FOLD_MAX) fold_len_q <= FOLD_MAX;
					else fold_len_q <= f_raw;
				end
				REG_VECTOR_LENGTH: begin
					if (l_raw == '0) vec_len_q <= LW'(1);
					else if (l_raw > LEN_MAX) vec_len_q <= LEN_MAX;
					else vec_len_q <= l_raw;
				end
				default: ;
			endcase
		end
	end

	assign last_bin         = {1'b0, pos_q} == vec_len_q - LW'(1);
	assign status.last_fold = {1'b0, fold_q} == fold_len_q - FW'(1);
	assign advance          = cmd.acc_write | cmd.div_start;

	// position and fold counters; a bin read on the first fold is taken as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fold_q <= '0;
		end else if (cfg_write) begin
			pos_q  <= '0;
			fold_q <= '0;
		end else if (advance) begin
			if (last_bin) begin
				pos_q  <= '0;
				fold_q <= status.last_fold ? '0 : fold_q + CW'(1);
			end else begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) sample_q <= sample;
	end

	// bin store
	always_ff @(posedge clk) begin
		if (cmd.acc_write) mem[pos_q] <= sum;
		rd_q <= mem[pos_q];
	end

	assign base = (fold_q == '0) ? '0 : rd_q;
	assign sum  = base + ACC_W'(sample_q);

	// restoring divider, one quotient bit a cycle
	assign trial = {rem_q[FW-2:0], dvd_q[ACC_W-1]};
	assign ge    = trial >= fold_len_q;

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q      <= sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);
			rem_q      <= '0;
			neg_q      <= sum[ACC_W-1];
			idx_q      <= pos_q;
			last_bin_q <= last_bin;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[ACC_W-2:0], ge};
			rem_q <= ge ? trial - fold_len_q : trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= NW'(ACC_W);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - NW'(1);
		end
	end

	assign status.div_last = cnt_q == NW'(1);
	assign quot            = neg_q ? ACC_W'(-dvd_q) : dvd_q;

	// result register
	assign status.out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			average_q   <= quot[SAMPLE_BITS-1:0];
			bin_index_q <= idx_q;
			last_q      <= last_bin_q;
		end
	end

	assign result_valid = result_valid_q;
	assign average      = average_q;
	assign bin_index    = bin_index_q;
	assign last         = last_q;

	`SEF_ASSERT_NOW(a_pos_in_range, 1'b1, {1'b0, pos_q} < vec_len_q, "position beyond vector length")
	`SEF_ASSERT_NOW(a_fold_in_range, 1'b1, {1'b0, fold_q} < fold_len_q, "fold count beyond folding")
	`SEF_ASSERT_NOW(a_load_when_free, cmd.out_load, !result_valid_q || !result_stall, "result word overwritten")
	`SEF_ASSERT_NEXT(a_div_counts, cmd.div_start, cnt_q == NW'(ACC_W), "divider not armed")

endmodule

[sv/synchronous_epoch_folder_core.sv]
// ----------------------------------------------------------------------------
// synchronous_epoch_folder_core
// epoch folder: sums a sample stream into period bins and emits bin averages
// ----------------------------------------------------------------------------
// usage
//   sample channel: one signed sample word per handshake (valid high, stall low)
//   result channel: average, bin_index and last, one word per bin on the
//   final fold of each vector only; last marks the final bin
//   cfg_write with cfg_index 0 sets folding, 1 sets vector_length; either
//   write restarts folding from bin 0 with empty bins
// sequence
//   an item that gives no result has a bin read, then an add and write
//   an item on the final fold runs a serial divider of SAMPLE_BITS +
//   log2(MAX_FOLDING) steps; samples stall until its result is loaded into
//   the result register, and the next item is taken after that
// reset and stall
//   reset gives folding 1, vector length MAX_BINS and empty bins at once;
//   no clearing pass, bins read as zero on the first fold of each vector
//   the result register holds while stalled; the next sample may be taken,
//   but a new result waits until the register is free
// ----------------------------------------------------------------------------
module synchronous_epoch_folder_core #(
	parameter int MAX_BINS    = 1024,
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_FOLDING = 4096
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [sef_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [(($clog2(MAX_FOLDING) > $clog2(MAX_BINS)) ?
		$clog2(MAX_FOLDING) : $clog2(MAX_BINS)):0]  cfg_data,
	input  logic                                   sample_valid,
	output logic                                   sample_stall,
	input  logic signed [SAMPLE_BITS-1:0]          sample,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic signed [SAMPLE_BITS-1:0]          average,
	output logic [$clog2(MAX_BINS)-1:0]            bin_index,
	output logic                                   last
);
	import sef_pkg::*;

	localparam int CFG_W = (($clog2(MAX_FOLDING) > $clog2(MAX_BINS)) ?
		$clog2(MAX_FOLDING) : $clog2(MAX_BINS)) + 1;

	cmd_t    cmd;
	status_t status;

	sef_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.status       (status),
		.cmd          (cmd)
	);

	sef_dp #(
		.MAX_BINS    (MAX_BINS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_FOLDING (MAX_FOLDING),
		.CFG_W       (CFG_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample       (sample),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.average      (average),
		.bin_index    (bin_index),
		.last         (last),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

[verif/sef_average_checker.sv]
// ----------------------------------------------------------------------------
// sef_average_checker
// watches the register port and both word channels of the epoch folder,
// keeps its own copy of the bin sums, position and fold count, works out
// the average each accepted final-fold sample yields and compares every
// accepted result word field by field with the oldest one still due
// ----------------------------------------------------------------------------
module sef_average_checker #(
	parameter int MAX_BINS    = 1024,
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_FOLDING = 4096,
	parameter int CFG_W       = 13
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [sef_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          sample_valid,
	input  logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic signed [SAMPLE_BITS-1:0] average,
	input  logic [$clog2(MAX_BINS)-1:0]   bin_index,
	input  logic                          last,
	output int                            fail_count,
	output int                            pending
);
	import sef_pkg::*;

	localparam int BIN_W = $clog2(MAX_BINS);
	localparam int ACC_W = SAMPLE_BITS + $clog2(MAX_FOLDING);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] average;
		logic [BIN_W-1:0]       bin_index;
		logic                   last;
	} fold_result_t;

	fold_result_t            averages_due[$];
	logic signed [ACC_W-1:0] bin_acc[MAX_BINS];
	int unsigned             period_pos;
	int unsigned             fold_idx;
	int unsigned             folding_reg;
	int unsigned             length_reg;
	int                      mismatches = 0;

	function automatic int unsigned folds_per_vector();
		if (folding_reg == 0) return 1;
		if (folding_reg > MAX_FOLDING) return MAX_FOLDING;
		return folding_reg;
	endfunction

	function automatic int unsigned bins_per_period();
		if (length_reg == 0) return 1;
		if (length_reg > MAX_BINS) return MAX_BINS;
		return length_reg;
	endfunction

	task automatic empty_bins();
		for (int i = 0; i < MAX_BINS; i++) begin
			bin_acc[i] = '0;
		end
		period_pos = 0;
		fold_idx   = 0;
	endtask

	task automatic fold_sample(input logic signed [SAMPLE_BITS-1:0] s);
		int unsigned  nf;
		int unsigned  nb;
		int unsigned  at;
		longint       total;
		fold_result_t due;
		nf = folds_per_vector();
		nb = bins_per_period();
		at = period_pos;
		if (at >= nb) at = 0;
		total = longint'(bin_acc[at]) + longint'(s);
		if (fold_idx >= nf - 1) begin
			due.average   = SAMPLE_BITS'(total / longint'(nf));
			due.bin_index = BIN_W'(at);
			due.last      = (at == nb - 1);
			averages_due.push_back(due);
			bin_acc[at] = '0;
		end else begin
			bin_acc[at] = ACC_W'(total);
		end
		if (at + 1 >= nb) begin
			period_pos = 0;
			fold_idx   = (fold_idx + 1 >= nf) ? 0 : fold_idx + 1;
		end else begin
			period_pos = at + 1;
		end
	endtask

	task automatic compare_word();
		fold_result_t due;
		if (averages_due.size() == 0) begin
			$error("result word with none due: average %0d, bin_index %0d, last %0b",
				average, bin_index, last);
			mismatches++;
		end else begin
			due = averages_due.pop_front();
			if (average !== due.average) begin
				$error("average: expected %0d, got %0d", $signed(due.average), average);
				mismatches++;
			end
			if (bin_index !== due.bin_index) begin
				$error("bin_index: expected %0d, got %0d", due.bin_index, bin_index);
				mismatches++;
			end
			if (last !== due.last) begin
				$error("last: expected %0b, got %0b", due.last, last);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			folding_reg = 1;
			length_reg  = MAX_BINS;
			empty_bins();
			averages_due.delete();
		end else begin
			if (result_valid && !result_stall) compare_word();
			if (cfg_write) begin
				if (cfg_index == REG_FOLDING) begin
					folding_reg = cfg_data;
					empty_bins();
				end else if (cfg_index == REG_VECTOR_LENGTH) begin
					length_reg = cfg_data[BIN_W:0];
					empty_bins();
				end
			end
			if (sample_valid && !sample_stall) fold_sample(sample);
		end
		pending    <= averages_due.size();
		fail_count <= mismatches;
	end

endmodule

[verif/synchronous_epoch_folder_core_tb.sv]
// ----------------------------------------------------------------------------
// synchronous_epoch_folder_core_tb
// drives sample words and register writes into the epoch folder, with random
// gaps on the sample side and random stall on the result side; a checker
// beside the block predicts and compares every average word. runs corner
// samples, then partial fold and truncation, then folding and vector length
// extremes, and random settings with partial vectors cut by a register write
// ----------------------------------------------------------------------------
module synchronous_epoch_folder_core_tb;

	import sef_pkg::*;

	localparam int MAX_BINS    = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_FOLDING = 4096;
	localparam int CFG_W       = (($clog2(MAX_FOLDING) > $clog2(MAX_BINS)) ?
		$clog2(MAX_FOLDING) : $clog2(MAX_BINS)) + 1;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 150;

	typedef enum int {
		MIX_ANY,
		MIX_HIGH,
		MIX_LOW,
		MIX_MIN,
		MIX_MAX
	} sample_mix_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_write;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [CFG_W-1:0]              cfg_data;
	logic                          sample_valid;
	logic                          sample_stall;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	logic signed [SAMPLE_BITS-1:0] average;
	logic [$clog2(MAX_BINS)-1:0]   bin_index;
	logic                          last;
	logic                          quiet = 1'b0;
	int                            mismatch_total;
	int                            words_due;

	synchronous_epoch_folder_core #(
		.MAX_BINS    (MAX_BINS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_FOLDING (MAX_FOLDING)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.average      (average),
		.bin_index    (bin_index),
		.last         (last)
	);

	sef_average_checker #(
		.MAX_BINS    (MAX_BINS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_FOLDING (MAX_FOLDING),
		.CFG_W       (CFG_W)
	) u_average_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.average      (average),
		.bin_index    (bin_index),
		.last         (last),
		.fail_count   (mismatch_total),
		.pending      (words_due)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		result_stall <= !quiet && ($urandom_range(0, 99) < 33);
	end

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input sample_mix_t mix);
		logic signed [SAMPLE_BITS-1:0] v;
		case (mix)
			MIX_HIGH: v = 16'sh7FFF - 16'($urandom_range(0, 255));
			MIX_LOW:  v = 16'sh8000 + 16'($urandom_range(0, 255));
			MIX_MIN:  v = 16'sh8000;
			MIX_MAX:  v = 16'sh7FFF;
			default: begin
				case ($urandom_range(0, 9))
					0:       v = 16'sh8000;
					1:       v = 16'sh7FFF;
					2:       v = 16'($urandom_range(0, 8)) - 16'sd4;
					default: v = 16'($urandom);
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_W-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic send_word(input logic signed [SAMPLE_BITS-1:0] s);
		while (!quiet && $urandom_range(0, 99) < 33) begin
			@(negedge clk);
			sample_valid <= 1'b0;
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		sample       <= s;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
	endtask

	// drop valid, wait for every due word, then let the last item finish
	task automatic settle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (words_due != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_plan(input int unsigned f, input int unsigned vl, input int n,
			input logic q, input sample_mix_t mix);
		if ($urandom_range(0, 1)) begin
			write_reg(REG_FOLDING, f);
			write_reg(REG_VECTOR_LENGTH, vl);
		end else begin
			write_reg(REG_VECTOR_LENGTH, vl);
			write_reg(REG_FOLDING, f);
		end
		quiet <= q;
		repeat (n) send_word(pick_sample(mix));
		settle();
		quiet <= 1'b0;
	endtask

	initial begin
		logic signed [SAMPLE_BITS-1:0] corner_words[12];
		int                            random_items;
		int unsigned                   f;
		int unsigned                   vl;
		int                            n;
		corner_words = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5555,
			16'shAAAA, 16'sh4000, 16'shC000, 16'sh0002, 16'shFFFE, 16'sh8001};
		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = REG_FOLDING;
		cfg_data     = '0;
		sample_valid = 1'b0;
		sample       = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: folding 1, every word averaged on its own
		foreach (corner_words[i]) send_word(corner_words[i]);
		settle();

		// partial fold thrown away by a length write, then truncation toward zero
		write_reg(REG_FOLDING, 2);
		write_reg(REG_VECTOR_LENGTH, 3);
		send_word(16'sd100);
		send_word(16'sd200);
		settle();
		write_reg(REG_VECTOR_LENGTH, 3);
		send_word(-16'sd3);
		send_word(16'sd3);
		send_word(16'sh8000);
		send_word(16'sd0);
		send_word(-16'sd2);
		send_word(16'sh8000);
		settle();

		// folding and length extremes, zero and saturated values
		run_plan(0, 13'h1FFF, 100, 1'b1, MIX_ANY);
		run_plan(13'h1FFF, 1, 40, 1'b0, MIX_MIN);
		run_plan(64, 1, 64, 1'b0, MIX_MAX);
		run_plan(3, 0, 30, 1'b0, MIX_ANY);
		run_plan(5, 13'h1801, 23, 1'b0, MIX_HIGH);
		run_plan(1, 1, 40, 1'b0, MIX_ANY);
		run_plan(2, 16, 40, 1'b0, MIX_LOW);

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				f  = 1;
				vl = $urandom_range(17, MAX_BINS);
				n  = vl + $urandom_range(0, vl);
			end else begin
				f  = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
				vl = (f > 8) ? $urandom_range(1, 4) : $urandom_range(1, 16);
				n  = f * vl * $urandom_range(1, 3) + $urandom_range(0, f * vl - 1);
			end
			if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
			run_plan(f, vl, n, 1'b0, sample_mix_t'($urandom_range(0, 2)));
			random_items += n;
		end

		if (mismatch_total == 0 && words_due == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/sef_pkg.sv
sv/sef_ctrl.sv
sv/sef_dp.sv
sv/synchronous_epoch_folder_core.sv
verif/sef_average_checker.sv
verif/synchronous_epoch_folder_core_tb.sv
